>>> rtl/rti_pkg.sv
// rti_pkg: widths, types and register indexes shared by the ray/triangle
// intersection pipeline. No dependencies.
`default_nettype none

package rti_pkg;

    localparam int DEN_W = 101;
    localparam int QUO_W = 32;
    localparam int NUM_W = DEN_W + QUO_W;

    typedef logic signed [32:0]  t_v33;
    typedef logic signed [65:0]  t_p66;
    typedef logic signed [66:0]  t_w67;
    typedef logic signed [67:0]  t_lo68;
    typedef logic signed [101:0] t_d102;

    typedef struct packed {
        logic miss;
        logic tneg;
        logic ovf;
    } t_side;

    localparam logic [2:0] CFG_ORIGIN_X  = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y  = 3'd1;
    localparam logic [2:0] CFG_ORIGIN_Z  = 3'd2;
    localparam logic [2:0] CFG_DIR_X     = 3'd3;
    localparam logic [2:0] CFG_DIR_Y     = 3'd4;
    localparam logic [2:0] CFG_DIR_Z     = 3'd5;
    localparam logic [2:0] CFG_THRESHOLD = 3'd6;

endpackage

`default_nettype wire

>>> rtl/rti_div.sv
// rti_div: pipelined restoring divider, one quotient bit per stage, three
// numerators against one shared divisor. Depends on rti_pkg.
`default_nettype none

module rti_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic [rti_pkg::DEN_W-1:0]    i_den,
    input  wire logic [rti_pkg::NUM_W-1:0]    i_num [3],
    input  wire rti_pkg::t_side               i_side,
    output logic                              o_valid,
    output logic [rti_pkg::QUO_W-1:0]         o_quo [3],
    output rti_pkg::t_side                    o_side
);
    import rti_pkg::*;

    logic [QUO_W-1:0] r_vld;
    logic [DEN_W-1:0] r_den  [QUO_W];
    t_side            r_side [QUO_W];
    logic [DEN_W-1:0] r_rem  [QUO_W][3];
    logic [QUO_W-1:0] r_nlo  [QUO_W][3];
    logic [QUO_W-1:0] r_quo  [QUO_W][3];

    logic [DEN_W-1:0] src_den  [QUO_W];
    t_side            src_side [QUO_W];
    logic [DEN_W-1:0] src_rem  [QUO_W][3];
    logic [QUO_W-1:0] src_nlo  [QUO_W][3];
    logic [QUO_W-1:0] src_quo  [QUO_W][3];
    logic [DEN_W:0]   trial    [QUO_W][3];
    logic [DEN_W:0]   diff     [QUO_W][3];
    logic             ge       [QUO_W][3];
    logic [DEN_W-1:0] n_rem    [QUO_W][3];

    always_comb begin
        src_den[0]  = i_den;
        src_side[0] = i_side;
        for (int l = 0; l < 3; l++) begin
            src_rem[0][l] = i_num[l][NUM_W-1:QUO_W];
            src_nlo[0][l] = i_num[l][QUO_W-1:0];
            src_quo[0][l] = '0;
        end
        for (int k = 1; k < QUO_W; k++) begin
            src_den[k]  = r_den[k-1];
            src_side[k] = r_side[k-1];
            for (int l = 0; l < 3; l++) begin
                src_rem[k][l] = r_rem[k-1][l];
                src_nlo[k][l] = r_nlo[k-1][l];
                src_quo[k][l] = r_quo[k-1][l];
            end
        end
        for (int k = 0; k < QUO_W; k++) begin
            for (int l = 0; l < 3; l++) begin
                trial[k][l] = {src_rem[k][l], src_nlo[k][l][QUO_W-1]};
                diff[k][l]  = trial[k][l] - {1'b0, src_den[k]};
                ge[k][l]    = trial[k][l] >= {1'b0, src_den[k]};
                n_rem[k][l] = ge[k][l] ? diff[k][l][DEN_W-1:0] : trial[k][l][DEN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[QUO_W-2:0], i_valid};
        end
        for (int k = 0; k < QUO_W; k++) begin
            r_den[k]  <= src_den[k];
            r_side[k] <= src_side[k];
            for (int l = 0; l < 3; l++) begin
                r_rem[k][l] <= n_rem[k][l];
                r_nlo[k][l] <= {src_nlo[k][l][QUO_W-2:0], 1'b0};
                r_quo[k][l] <= {src_quo[k][l][QUO_W-2:0], ge[k][l]};
            end
        end
    end

    assign o_valid = r_vld[QUO_W-1];
    assign o_side  = r_side[QUO_W-1];
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            o_quo[l] = r_quo[QUO_W-1][l];
        end
    end

endmodule

`default_nettype wire

>>> rtl/ray_triangle_intersect.sv
// ray_triangle_intersect: Moller-Trumbore test of streamed triangles against
// a configured ray, signed Q16.16. Depends on rti_pkg and rti_div.
// One transaction per cycle; the 9-stage front end feeds the 32-stage
// bit-per-cycle divider, followed by an output register. The result
// side cannot stall, so o_busy stays low. Synchronous active-low reset
// clears the pipeline valids and loads the register defaults.
`default_nettype none

module ray_triangle_intersect (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic signed [31:0] i_a_x,
    input  wire logic signed [31:0] i_a_y,
    input  wire logic signed [31:0] i_a_z,
    input  wire logic signed [31:0] i_b_x,
    input  wire logic signed [31:0] i_b_y,
    input  wire logic signed [31:0] i_b_z,
    input  wire logic signed [31:0] i_c_x,
    input  wire logic signed [31:0] i_c_y,
    input  wire logic signed [31:0] i_c_z,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    output logic                    o_done,
    output logic                    o_hit,
    output logic signed [31:0]      o_hit_distance,
    output logic [16:0]             o_bary_u,
    output logic [16:0]             o_bary_v
);
    import rti_pkg::*;

    localparam int DOT_DET = 0;
    localparam int DOT_UN  = 1;
    localparam int DOT_VN  = 2;
    localparam int DOT_TN  = 3;
    localparam int LANE_U  = 0;
    localparam int LANE_V  = 1;
    localparam int LANE_T  = 2;

    // configuration
    logic signed [31:0] r_org [3];
    logic signed [31:0] r_dir [3];
    logic [31:0]        r_thr;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_dir[0] <= '0;
            r_dir[1] <= '0;
            r_dir[2] <= 32'sd65536;
            r_thr    <= 32'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_X:  r_org[0] <= i_cfg_data;
                CFG_ORIGIN_Y:  r_org[1] <= i_cfg_data;
                CFG_ORIGIN_Z:  r_org[2] <= i_cfg_data;
                CFG_DIR_X:     r_dir[0] <= i_cfg_data;
                CFG_DIR_Y:     r_dir[1] <= i_cfg_data;
                CFG_DIR_Z:     r_dir[2] <= i_cfg_data;
                CFG_THRESHOLD: r_thr    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic       accept;
    logic [8:0] r_vld;

    assign accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[7:0], accept};
        end
    end

    // stage 1: edges and origin offset
    logic signed [31:0] va [3];
    logic signed [31:0] vb [3];
    logic signed [31:0] vc [3];
    t_v33 r1_e1 [3], r1_e2 [3], r1_s [3], r1_dir [3];

    assign va = '{i_a_x, i_a_y, i_a_z};
    assign vb = '{i_b_x, i_b_y, i_b_z};
    assign vc = '{i_c_x, i_c_y, i_c_z};

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r1_e1[k]  <= t_v33'(vb[k]) - t_v33'(va[k]);
            r1_e2[k]  <= t_v33'(vc[k]) - t_v33'(va[k]);
            r1_s[k]   <= t_v33'(r_org[k]) - t_v33'(va[k]);
            r1_dir[k] <= t_v33'(r_dir[k]);
        end
    end

    // stage 2: cross product terms; stage 3: differences
    t_p66 r2_pa [3], r2_pb [3], r2_qa [3], r2_qb [3];
    t_v33 r2_e1 [3], r2_e2 [3], r2_s [3], r2_dir [3];
    t_w67 r3_p [3], r3_q [3];
    t_v33 r3_e1 [3], r3_e2 [3], r3_s [3], r3_dir [3];

    for (genvar k = 0; k < 3; k++) begin : g_cross
        localparam int I1 = (k + 1) % 3;
        localparam int I2 = (k + 2) % 3;
        always_ff @(posedge i_clk) begin
            r2_pa[k]  <= r1_dir[I1] * r1_e2[I2];
            r2_pb[k]  <= r1_dir[I2] * r1_e2[I1];
            r2_qa[k]  <= r1_s[I1] * r1_e1[I2];
            r2_qb[k]  <= r1_s[I2] * r1_e1[I1];
            r2_e1[k]  <= r1_e1[k];
            r2_e2[k]  <= r1_e2[k];
            r2_s[k]   <= r1_s[k];
            r2_dir[k] <= r1_dir[k];
            r3_p[k]   <= t_w67'(r2_pa[k]) - t_w67'(r2_pb[k]);
            r3_q[k]   <= t_w67'(r2_qa[k]) - t_w67'(r2_qb[k]);
            r3_e1[k]  <= r2_e1[k];
            r3_e2[k]  <= r2_e2[k];
            r3_s[k]   <= r2_s[k];
            r3_dir[k] <= r2_dir[k];
        end
    end

    // stages 4-6: dot products, long operand split at bit 34
    t_v33  da [4][3];
    t_w67  db [4][3];
    t_lo68 r4_lo [4][3];
    t_p66  r4_hi [4][3];
    t_d102 r5_prod [4][3];
    t_d102 r6_sum [4];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            da[DOT_DET][k] = r3_e1[k];
            db[DOT_DET][k] = r3_p[k];
            da[DOT_UN][k]  = r3_s[k];
            db[DOT_UN][k]  = r3_p[k];
            da[DOT_VN][k]  = r3_dir[k];
            db[DOT_VN][k]  = r3_q[k];
            da[DOT_TN][k]  = r3_e2[k];
            db[DOT_TN][k]  = r3_q[k];
        end
    end

    for (genvar j = 0; j < 4; j++) begin : g_dot
        for (genvar k = 0; k < 3; k++) begin : g_term
            always_ff @(posedge i_clk) begin
                r4_lo[j][k]   <= da[j][k] * $signed({1'b0, db[j][k][33:0]});
                r4_hi[j][k]   <= da[j][k] * $signed(db[j][k][66:34]);
                r5_prod[j][k] <= (t_d102'(r4_hi[j][k]) <<< 34) + t_d102'(r4_lo[j][k]);
            end
        end
        always_ff @(posedge i_clk) begin
            r6_sum[j] <= r5_prod[j][0] + r5_prod[j][1] + r5_prod[j][2];
        end
    end

    // stage 7: negate all four sums when det is negative
    t_d102 r7_val [4];

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 4; j++) begin
            r7_val[j] <= r6_sum[DOT_DET][101] ? -r6_sum[j] : r6_sum[j];
        end
    end

    // stage 8: miss decision, |t| numerator
    logic signed [102:0] uv_sum;
    logic                miss;
    logic [DEN_W-1:0]    r8_det, r8_un, r8_vn;
    logic [101:0]        r8_tabs;
    logic                r8_miss, r8_tneg;

    assign uv_sum = 103'(r7_val[DOT_UN]) + 103'(r7_val[DOT_VN]);
    assign miss = (r7_val[DOT_DET] == '0)
               || (r7_val[DOT_DET][DEN_W-1:0] < DEN_W'({r_thr, 32'h0}))
               || r7_val[DOT_UN][101]
               || (r7_val[DOT_UN] > r7_val[DOT_DET])
               || r7_val[DOT_VN][101]
               || (uv_sum > 103'(r7_val[DOT_DET]));

    always_ff @(posedge i_clk) begin
        r8_det  <= r7_val[DOT_DET][DEN_W-1:0];
        r8_un   <= r7_val[DOT_UN][DEN_W-1:0];
        r8_vn   <= r7_val[DOT_VN][DEN_W-1:0];
        r8_tneg <= r7_val[DOT_TN][101];
        r8_tabs <= r7_val[DOT_TN][101] ? 102'(-r7_val[DOT_TN]) : 102'(r7_val[DOT_TN]);
        r8_miss <= miss;
    end

    // stage 9: overflow check and divider operands
    logic             ovf;
    logic [DEN_W-1:0] r9_den;
    logic [NUM_W-1:0] r9_num [3];
    t_side            r9_side;

    assign ovf = 118'(r8_tabs) >= {r8_det, 16'h0};

    always_ff @(posedge i_clk) begin
        r9_den         <= r8_det;
        r9_num[LANE_U] <= NUM_W'({r8_un, 16'h0});
        r9_num[LANE_V] <= NUM_W'({r8_vn, 16'h0});
        r9_num[LANE_T] <= ovf ? '0 : NUM_W'({r8_tabs, 16'h0});
        r9_side        <= '{miss: r8_miss, tneg: r8_tneg, ovf: ovf};
    end

    logic             div_vld;
    logic [QUO_W-1:0] div_quo [3];
    t_side            div_side;

    rti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[8]),
        .i_den   (r9_den),
        .i_num   (r9_num),
        .i_side  (r9_side),
        .o_valid (div_vld),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    // output stage: saturation and zeroing on a miss
    logic                 sat;
    logic signed [31:0]   sat_dist;
    logic                 r_done, r_hit;
    logic signed [31:0]   r_dist;
    logic [16:0]          r_u, r_v;

    always_comb begin
        if (div_side.tneg) begin
            sat      = div_side.ovf || (div_quo[LANE_T] > 32'h8000_0000);
            sat_dist = sat ? 32'sh8000_0000 : $signed(32'd0 - div_quo[LANE_T]);
        end else begin
            sat      = div_side.ovf || div_quo[LANE_T][31];
            sat_dist = sat ? 32'sh7FFF_FFFF : $signed(div_quo[LANE_T]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= div_vld;
        end
        r_hit  <= !div_side.miss;
        r_dist <= div_side.miss ? '0 : sat_dist;
        r_u    <= div_side.miss ? '0 : div_quo[LANE_U][16:0];
        r_v    <= div_side.miss ? '0 : div_quo[LANE_V][16:0];
    end

    assign o_done         = r_done;
    assign o_hit          = r_hit;
    assign o_hit_distance = r_dist;
    assign o_bary_u       = r_u;
    assign o_bary_v       = r_v;

    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##42 o_done)
        else $error("transaction did not complete after 42 cycles");

    a_miss_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit) |-> (o_hit_distance == 0 && o_bary_u == 0 && o_bary_v == 0))
        else $error("miss with nonzero result fields");

    a_bary_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_hit) |-> (o_bary_u <= 17'h10000 && o_bary_v <= 17'h10000))
        else $error("barycentric coordinate above one");

endmodule

`default_nettype wire

>>> verif/ray_triangle_intersect_tb.sv
// ray_triangle_intersect_tb: self-checking bench for the ray/triangle intersection block.
// Depends on rti_pkg and the ray_triangle_intersect RTL. Exact wide-integer predictor,
// directed table then randomised triangles over several ray settings.
`default_nettype none

module ray_triangle_intersect_tb;
    import rti_pkg::*;

    localparam int          HALF_PERIOD = 6;
    localparam int          LATENCY     = 42;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          N_PHASES    = 8;
    localparam int          PER_PHASE   = 250;
    localparam logic [2:0]  CFG_NONE    = 3'd7;
    localparam logic signed [31:0] ONE  = 32'sd65536;
    localparam logic signed [31:0] SMAX = 32'sh7fffffff;
    localparam logic signed [31:0] SMIN = 32'sh80000000;

    typedef logic signed [127:0] t_s128;
    typedef logic [8:0][31:0] t_tri;      // [0]=a_x .. [8]=c_z

    typedef struct packed {
        logic        hit;
        logic [31:0] distance;
        logic [16:0] u;
        logic [16:0] v;
    } t_isect;

    typedef struct packed {
        t_tri   vtx;
        logic   known;
        t_isect want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic signed [31:0] i_a_x = '0, i_a_y = '0, i_a_z = '0;
    logic signed [31:0] i_b_x = '0, i_b_y = '0, i_b_z = '0;
    logic signed [31:0] i_c_x = '0, i_c_y = '0, i_c_z = '0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        o_busy, o_cfg_ready, o_done, o_hit;
    logic signed [31:0] o_hit_distance;
    logic [16:0] o_bary_u, o_bary_v;

    ray_triangle_intersect dut (.*);

    always #HALF_PERIOD i_clk = ~i_clk;

    // ray registers as the block should hold them
    logic [31:0] ray_reg [7];
    t_isect      pending_isect [$];
    int          errors = 0, cycles = 0, n_sent = 0, n_hits = 0, n_checked = 0;
    int          idle_pct = 0;

    function automatic t_isect trace_triangle(input t_tri vtx);
        t_s128 ax, ay, az, e1x, e1y, e1z, e2x, e2y, e2z, dx, dy, dz, sx, sy, sz;
        t_s128 px, py, pz, qx, qy, qz, det, un, vn, tn, thr, mag;
        t_isect r;
        r = '0;
        ax = t_s128'($signed(vtx[0])); ay = t_s128'($signed(vtx[1]));
        az = t_s128'($signed(vtx[2]));
        e1x = t_s128'($signed(vtx[3])) - ax; e1y = t_s128'($signed(vtx[4])) - ay;
        e1z = t_s128'($signed(vtx[5])) - az;
        e2x = t_s128'($signed(vtx[6])) - ax; e2y = t_s128'($signed(vtx[7])) - ay;
        e2z = t_s128'($signed(vtx[8])) - az;
        dx = t_s128'($signed(ray_reg[CFG_DIR_X])); dy = t_s128'($signed(ray_reg[CFG_DIR_Y]));
        dz = t_s128'($signed(ray_reg[CFG_DIR_Z]));
        sx = t_s128'($signed(ray_reg[CFG_ORIGIN_X])) - ax;
        sy = t_s128'($signed(ray_reg[CFG_ORIGIN_Y])) - ay;
        sz = t_s128'($signed(ray_reg[CFG_ORIGIN_Z])) - az;
        px = dy * e2z - dz * e2y; py = dz * e2x - dx * e2z; pz = dx * e2y - dy * e2x;
        qx = sy * e1z - sz * e1y; qy = sz * e1x - sx * e1z; qz = sx * e1y - sy * e1x;
        det = e1x * px + e1y * py + e1z * pz;
        un  = sx * px + sy * py + sz * pz;
        vn  = dx * qx + dy * qy + dz * qz;
        tn  = e2x * qx + e2y * qy + e2z * qz;
        if (det < 0) begin
            det = -det; un = -un; vn = -vn; tn = -tn;
        end
        thr = t_s128'({64'd0, ray_reg[CFG_THRESHOLD], 32'd0});
        if (det == 0 || det < thr) return r;
        if (un < 0 || un > det || vn < 0 || un + vn > det) return r;
        r.hit = 1'b1;
        r.u = 17'((un <<< 16) / det);
        r.v = 17'((vn <<< 16) / det);
        mag = ((tn < 0 ? -tn : tn) <<< 16) / det;
        if (tn < 0) r.distance = (mag > 128'sh80000000) ? 32'h80000000 : 32'(-mag);
        else        r.distance = (mag > 128'sh7fffffff) ? 32'h7fffffff : 32'(mag);
        return r;
    endfunction

    task automatic send_triangle(input t_tri vtx, input logic known, input t_isect want);
        t_isect got;
        i_start <= 1'b1;
        {i_c_z, i_c_y, i_c_x, i_b_z, i_b_y, i_b_x, i_a_z, i_a_y, i_a_x} <= vtx;
        do @(posedge i_clk); while (o_busy);
        got = trace_triangle(vtx);
        if (known && got != want) begin
            $error("directed expectation disagrees with predictor: %h vs %h", want, got);
            errors++;
        end
        pending_isect = {pending_isect, known ? want : got};
        n_sent++;
        if ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic drain;
        i_start <= 1'b0;
        while (pending_isect.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx != CFG_NONE) ray_reg[idx] = data;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_s(input int span);
        return 32'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    // triangle placed around a point of the ray, so many of them are hits
    function automatic t_tri aimed_triangle();
        t_tri vtx;
        logic signed [63:0] tt, ctr;
        tt = 64'($signed($urandom_range(0, 24 << 16))) - (4 << 16);
        for (int k = 0; k < 3; k++) begin
            ctr = 64'($signed(ray_reg[k])) + ((64'($signed(ray_reg[3 + k])) * tt) >>> 16);
            for (int j = 0; j < 3; j++)
                vtx[3 * j + k] = 32'(ctr) + rand_s(1 << 18);
        end
        return vtx;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_isect want;
        if (i_rst_n && o_done) begin
            if (pending_isect.size() == 0) begin
                $error("result with no triangle outstanding");
                errors++;
            end else begin
                want = pending_isect.pop_front();
                n_checked++;
                if (o_hit) n_hits++;
                if (o_hit != want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, o_hit); errors++;
                end
                if (o_hit_distance != want.distance) begin
                    $error("hit_distance: expected %0d, got %0d", $signed(want.distance),
                           o_hit_distance); errors++;
                end
                if (o_bary_u != want.u) begin
                    $error("bary_u: expected %0d, got %0d", want.u, o_bary_u); errors++;
                end
                if (o_bary_v != want.v) begin
                    $error("bary_v: expected %0d, got %0d", want.v, o_bary_v); errors++;
                end
            end
        end
    end

    initial begin
        t_row   rows [12];
        t_tri   vtx;
        int     sel;
        ray_reg = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd1};

        // ray along +z from the origin after reset
        rows[0]  = '{'0, 1'b1, '0};                         // all vertices zero
        rows[1]  = '{{9{SMAX}}, 1'b1, '0};                  // degenerate at maximum
        rows[2]  = '{{9{SMIN}}, 1'b1, '0};                  // degenerate at minimum
        rows[3]  = '{{ONE, 32'd0, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0},
                     1'b1, '0};                             // plane contains the ray
        rows[4]  = '{{5*ONE, ONE, -ONE, 5*ONE, -ONE, ONE, 5*ONE, -ONE, -ONE}, 1'b0, '0};
        rows[5]  = '{{5*ONE, -ONE, ONE, 5*ONE, -ONE, ONE, 5*ONE, -ONE, -ONE}, 1'b0, '0};
        rows[6]  = '{{-5*ONE, ONE, -ONE, -5*ONE, -ONE, ONE, -5*ONE, -ONE, -ONE}, 1'b0, '0};
        rows[7]  = '{{5*ONE, ONE, 11*ONE, 5*ONE, -ONE, 11*ONE, 5*ONE, -ONE, 9*ONE}, 1'b0, '0};
        rows[8]  = '{{5*ONE, ONE, 32'd0, 5*ONE, 32'd0, ONE, 5*ONE, 32'd0, 32'd0},
                     1'b0, '0};
        rows[9]  = '{{5*ONE, 32'd1, 32'd0, 5*ONE, 32'd0, 32'd1, 5*ONE, 32'd0, 32'd0},
                     1'b0, '0};                             // below threshold
        rows[10] = '{{32'd0, SMAX, SMIN, SMIN, SMIN, SMAX, SMAX, SMIN, SMIN}, 1'b0, '0};
        rows[11] = '{{SMAX, SMAX, SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, SMIN}, 1'b0, '0};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) send_triangle(rows[r].vtx, rows[r].known, rows[r].want);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            idle_pct = (ph < 3) ? 32 : (ph < 6) ? 85 : 0;
            case (ph)
                1: begin
                    for (int k = 0; k < 3; k++) write_reg(3'(k), SMAX);
                    for (int k = 3; k < 6; k++) write_reg(3'(k), SMIN);
                    write_reg(CFG_THRESHOLD, 32'd0);
                end
                2: begin
                    for (int k = 0; k < 3; k++) write_reg(3'(k), SMIN);
                    for (int k = 3; k < 6; k++) write_reg(3'(k), SMAX);
                    write_reg(CFG_THRESHOLD, 32'hffffffff);
                end
                3: begin                                    // tiny direction: far hits saturate
                    write_reg(CFG_DIR_X, 32'd1);
                    write_reg(CFG_DIR_Y, 32'd0);
                    write_reg(CFG_DIR_Z, 32'hffffffff);
                    for (int k = 0; k < 3; k++) write_reg(3'(k), rand_s(1 << 20));
                    write_reg(CFG_THRESHOLD, 32'd0);
                end
                default: begin
                    for (int k = 0; k < 6; k++) write_reg(3'(k), rand_s(k < 3 ? 1 << 20 : 1 << 17));
                    write_reg(CFG_THRESHOLD, $urandom_range(0, 256));
                    write_reg(CFG_NONE, $urandom);
                end
            endcase
            for (int n = 0; n < PER_PHASE; n++) begin
                sel = $urandom_range(99);
                if (sel < 70) vtx = aimed_triangle();
                else if (sel < 85) for (int k = 0; k < 9; k++) vtx[k] = $urandom;
                else for (int k = 0; k < 9; k++) vtx[k] = rand_s(1 << 20);
                send_triangle(vtx, 1'b0, '0);
            end
        end

        drain();
        $display("Checked %0d of %0d triangles over %0d ray settings, %0d hits.",
                 n_checked, n_sent, N_PHASES + 1, n_hits);
        if (errors == 0 && pending_isect.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

`default_nettype wire
